>>> src/sitf_pkg.sv
// Shared types and constants for the sorted IPv4 address pool.
`default_nettype none
package sitf_pkg;

	localparam int ADDR_W          = 32;
	localparam int OCTET_W         = 8;
	localparam int POOL_DEPTH_DEF  = 64;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_ALL   = 2'd0,
		MODE_FIRST = 2'd1,
		MODE_TWO   = 2'd2,
		MODE_ANY   = 2'd3
	} qmode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic load;     // insert the broadcast address
		logic capture;  // copy entries into the scan chain
		logic shift;    // move the scan chain one cell toward the head
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> src/sorted_ipv4_table_filter.sv
// Sorted IPv4 address pool with filtered read-out, built as a chain of cells.
// Input channel (in_valid/in_ready): operation selects a load or a query.
// A load beat inserts address into the descending pool and gives no result;
// loads are taken one per cycle while the block is idle, the whole chain shifting in parallel.
// When the pool already holds POOL_DEPTH addresses the load is dropped and
// the sticky overflowed flag is set.
// A query beat copies the pool into the scan chain, which then moves one
// entry per cycle past the filter at its head. One match is held back until
// the next is seen, so the final one can carry last_result. The first result
// is registered when a second match is seen, or else in the flush state; the
// query occupies the block until the flush state registers its last beat, which
// waits out any output stall, and no input is taken during that time.
// A query with no match gives one beat with found clear and last_result set.
// Output channel (out_valid/out_ready) ends in a result register; while the
// receiver stalls, the scan holds whenever a second match is waiting.
// Reset empties the pool, clears the overflow flag and drops any result.
`default_nettype none
module sorted_ipv4_table_filter
	import sitf_pkg::*;
#(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic [ADDR_W-1:0]  address,
	input  wire logic [1:0]         query_mode,
	input  wire logic [OCTET_W-1:0] key_first,
	input  wire logic [OCTET_W-1:0] key_second,
	input  wire logic [OCTET_W-1:0] match_octet,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [ADDR_W-1:0]       match_address,
	output logic                    found,
	output logic                    last_result,
	output logic                    overflowed
);

	localparam int CNT_W = $clog2(POOL_DEPTH + 1);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   left_q;
	logic               flag_q;
	logic               pend_v_q;
	logic [ADDR_W-1:0]  pend_addr_q;
	qmode_t             mode_q;
	logic [OCTET_W-1:0] key_first_q, key_second_q, match_octet_q;
	logic               out_valid_q, found_q, last_q, ovf_q;
	logic [ADDR_W-1:0]  out_addr_q;

	logic               accept, is_load, is_query, full, out_free, head_hit;
	logic               step, emit, emit_found, emit_last;
	logic [ADDR_W-1:0]  emit_addr;
	cell_ctl_t          ctl;

	logic [POOL_DEPTH-1:0] valid_v, keep_v;
	logic [ADDR_W-1:0]     entry_a [POOL_DEPTH];
	logic [ADDR_W-1:0]     scan_a  [POOL_DEPTH];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_load  = accept && (operation == OP_LOAD);
	assign is_query = accept && (operation == OP_QUERY);
	assign full     = (count_q == CNT_W'(POOL_DEPTH));
	assign out_free = !out_valid_q || out_ready;

	assign ctl.load    = is_load && !full;
	assign ctl.capture = is_query;
	assign ctl.shift   = step;

	for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
		logic              lv, lk;
		logic [ADDR_W-1:0] le, rs;
		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign lk = 1'b1;
			assign le = '0;
		end else begin : g_body
			assign lv = valid_v[i-1];
			assign lk = keep_v[i-1];
			assign le = entry_a[i-1];
		end
		if (i == POOL_DEPTH - 1) begin : g_tail
			assign rs = '0;
		end else begin : g_mid
			assign rs = scan_a[i+1];
		end
		sitf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.ins_addr   (address),
			.left_valid (lv),
			.left_keep  (lk),
			.left_entry (le),
			.right_scan (rs),
			.valid      (valid_v[i]),
			.keep       (keep_v[i]),
			.entry      (entry_a[i]),
			.scan       (scan_a[i])
		);
	end

	sitf_match u_match (
		.address     (scan_a[0]),
		.query_mode  (mode_q),
		.key_first   (key_first_q),
		.key_second  (key_second_q),
		.match_octet (match_octet_q),
		.hit         (head_hit)
	);

	always_comb begin
		state_d    = state_q;
		step       = 1'b0;
		emit       = 1'b0;
		emit_addr  = pend_addr_q;
		emit_found = 1'b1;
		emit_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (is_query) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (left_q == '0) begin
					state_d = ST_FLUSH;
				end else if (!(head_hit && pend_v_q && !out_free)) begin
					step = 1'b1;
					// a newer match releases the held one
					emit = head_hit && pend_v_q;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_last  = 1'b1;
					emit_found = pend_v_q;
					emit_addr  = pend_v_q ? pend_addr_q : '0;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			flag_q      <= 1'b0;
			left_q      <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (is_load) begin
				if (full) flag_q <= 1'b1;
				else      count_q <= count_q + CNT_W'(1);
			end
			if (is_query) begin
				left_q   <= count_q;
				pend_v_q <= 1'b0;
			end else if (step) begin
				left_q <= left_q - CNT_W'(1);
				if (head_hit) pend_v_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			mode_q        <= qmode_t'(query_mode);
			key_first_q   <= key_first;
			key_second_q  <= key_second;
			match_octet_q <= match_octet;
		end
		if (step && head_hit) pend_addr_q <= scan_a[0];
		if (emit) begin
			out_addr_q <= emit_addr;
			found_q    <= emit_found;
			last_q     <= emit_last;
			// hold the flag as it stood for this query
			ovf_q      <= flag_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = out_addr_q;
	assign found         = found_q;
	assign last_result   = last_q;
	assign overflowed    = ovf_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(POOL_DEPTH))
		else $error("entry count beyond pool depth");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_v) == int'(count_q))
		else $error("cell valid bits disagree with entry count");

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		flag_q |=> flag_q)
		else $error("overflow flag cleared without reset");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> last_q)
		else $error("not-found beat without last mark");
`endif

endmodule
`default_nettype wire

>>> src/sitf_cell.sv
// One cell of the sorted chain: a pool entry plus its scan register.
`default_nettype none
module sitf_cell
	import sitf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_ctl_t         ctl,
	input  wire logic [ADDR_W-1:0] ins_addr,
	input  wire logic              left_valid,
	input  wire logic              left_keep,
	input  wire logic [ADDR_W-1:0] left_entry,
	input  wire logic [ADDR_W-1:0] right_scan,
	output logic                   valid,
	output logic                   keep,
	output logic [ADDR_W-1:0]      entry,
	output logic [ADDR_W-1:0]      scan
);

	logic              valid_q;
	logic [ADDR_W-1:0] entry_q;
	logic [ADDR_W-1:0] scan_q;

	// equal entries stay ahead of the new address
	assign keep  = valid_q && (entry_q >= ins_addr);
	assign valid = valid_q;
	assign entry = entry_q;
	assign scan  = scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load && !keep) begin
			valid_q <= valid_q | left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && !keep) begin
			entry_q <= left_keep ? ins_addr : left_entry;
		end
		if (ctl.capture) begin
			scan_q <= entry_q;
		end else if (ctl.shift) begin
			scan_q <= right_scan;
		end
	end

endmodule
`default_nettype wire

>>> src/sitf_match.sv
// Query filter applied to the address at the head of the scan chain.
`default_nettype none
module sitf_match
	import sitf_pkg::*;
(
	input  wire logic [ADDR_W-1:0]  address,
	input  wire qmode_t             query_mode,
	input  wire logic [OCTET_W-1:0] key_first,
	input  wire logic [OCTET_W-1:0] key_second,
	input  wire logic [OCTET_W-1:0] match_octet,
	output logic                    hit
);

	logic [OCTET_W-1:0] o0, o1, o2, o3;

	assign o0 = address[31:24];
	assign o1 = address[23:16];
	assign o2 = address[15:8];
	assign o3 = address[7:0];

	always_comb begin
		case (query_mode)
			MODE_ALL:   hit = 1'b1;
			MODE_FIRST: hit = (o0 == key_first);
			MODE_TWO:   hit = (o0 == key_first) && (o1 == key_second);
			MODE_ANY:   hit = (o0 == match_octet) || (o1 == match_octet) ||
			                  (o2 == match_octet) || (o3 == match_octet);
			default:    hit = 1'b0;
		endcase
	end

endmodule
`default_nettype wire
